>>> hdl/ttli_pkg.sv
package ttli_pkg;

    localparam int TABLE_DEPTH_DEF   = 4096;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int FIELD_W           = 32;
    localparam int NFIELD            = 7;
    localparam int COUNT_W           = 13;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_DURATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIX_DOF_MODE   = 2'd2;

    localparam logic [1:0] BND_INTERP = 2'd0;
    localparam logic [1:0] BND_FIRST  = 2'd1;
    localparam logic [1:0] BND_LAST   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_LO_RD,
        ST_HI_RD,
        ST_DIV,
        ST_MUL,
        ST_EMIT_RD,
        ST_OUT
    } t_state;

    typedef logic [FIELD_W-1:0] t_row [NFIELD];

endpackage

>>> hdl/ttli_mem.sv
module ttli_mem #(
    parameter int DEPTH = ttli_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [ttli_pkg::FIELD_W-1:0] i_wtime,
    input  ttli_pkg::t_row             i_wrow,
    input  logic [AW-1:0]              i_raddr,
    output logic [ttli_pkg::FIELD_W-1:0] o_rtime,
    output ttli_pkg::t_row             o_rrow
);
    import ttli_pkg::*;

    logic [FIELD_W-1:0] r_time_mem [DEPTH];
    logic [FIELD_W*NFIELD-1:0] r_row_mem [DEPTH];
    logic [FIELD_W*NFIELD-1:0] r_rrow;
    logic [FIELD_W*NFIELD-1:0] w_wrow;

    always_comb begin
        for (int k = 0; k < NFIELD; k++) begin
            w_wrow[k*FIELD_W +: FIELD_W] = i_wrow[k];
            o_rrow[k] = r_rrow[k*FIELD_W +: FIELD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_time_mem[i_waddr] <= i_wtime;
            r_row_mem[i_waddr]  <= w_wrow;
        end
        o_rtime <= r_time_mem[i_raddr];
        r_rrow  <= r_row_mem[i_raddr];
    end
endmodule

>>> hdl/ttli_div.sv
// Restoring divider, one quotient bit per cycle. Numerator never exceeds the
// denominator, so the quotient fits in FB+1 bits and is saturated to FB bits.
module ttli_div #(
    parameter int FB = ttli_pkg::FRACTION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ttli_pkg::FIELD_W-1:0] i_num,
    input  logic [ttli_pkg::FIELD_W-1:0] i_den,
    output logic                         o_done,
    output logic [FB-1:0]                o_frac
);
    import ttli_pkg::*;
    localparam int CW = $clog2(FB + 2);

    logic [FIELD_W:0]   r_rem;
    logic [FIELD_W-1:0] r_den;
    logic [FB:0]        r_quo;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic [FIELD_W+1:0] w_trial;

    assign w_trial = {r_rem, 1'b0} - {2'b00, r_den};
    assign o_done  = r_busy && (r_cnt == '0);
    assign o_frac  = r_quo[FB] ? {FB{1'b1}} : r_quo[FB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(FB);
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quo  <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (!w_trial[FIELD_W+1]) begin
                r_rem <= w_trial[FIELD_W:0];
                r_quo <= {r_quo[FB-1:0], 1'b1};
            end else begin
                r_rem <= {r_rem[FIELD_W-1:0], 1'b0};
                r_quo <= {r_quo[FB-1:0], 1'b0};
            end
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end
endmodule

>>> hdl/ttli_lerp.sv
// One field per cycle: lo + floor((hi - lo) * f / 2^FB). The difference is
// registered before the multiply, the product before the shift.
module ttli_lerp #(
    parameter int FB = ttli_pkg::FRACTION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  ttli_pkg::t_row               i_lo,
    input  ttli_pkg::t_row               i_hi,
    input  logic [FB-1:0]                i_frac,
    output logic                         o_done,
    output ttli_pkg::t_row               o_res
);
    import ttli_pkg::*;
    localparam int KW = $clog2(NFIELD + 2);

    logic                       r_busy;
    logic [KW-1:0]              r_k;
    logic signed [FIELD_W:0]    r_diff;
    logic signed [FIELD_W:0]    r_base;
    logic                       r_dv;
    logic [KW-1:0]              r_dk;
    logic signed [FIELD_W+FB+1:0] r_prod;
    logic signed [FIELD_W:0]    r_pbase;
    logic                       r_pv;
    logic [KW-1:0]              r_pk;
    logic                       r_done;
    logic [2:0]                 w_ki;
    logic signed [FIELD_W+FB+1:0] w_sum;

    assign w_ki  = r_k[2:0];
    assign w_sum = r_prod >>> FB;
    // Done rises with the write of the last field, so the whole row is valid.
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_dv   <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 1'b1;
                if (r_k == KW'(NFIELD - 1)) r_busy <= 1'b0;
            end
            r_dv   <= r_busy;
            r_pv   <= r_dv;
            r_done <= r_pv && (r_pk == KW'(NFIELD - 1));
        end
        r_diff  <= $signed({i_hi[w_ki][FIELD_W-1], i_hi[w_ki]})
                 - $signed({i_lo[w_ki][FIELD_W-1], i_lo[w_ki]});
        r_base  <= $signed({i_lo[w_ki][FIELD_W-1], i_lo[w_ki]});
        r_dk    <= r_k;
        r_prod  <= r_diff * $signed({1'b0, i_frac});
        r_pbase <= r_base;
        r_pk    <= r_dk;
        if (r_pv) o_res[r_pk[2:0]] <= FIELD_W'(r_pbase + w_sum[FIELD_W:0]);
    end
endmodule

>>> hdl/time_table_linear_interpolator_top.sv
// Channel | Dir | Transfer content
// s_axis  | in  | tuser = func; tdata = sample_index, sample_time, pos_x..heading
// m_axis  | out | tuser = boundary; tdata = out_x..out_vz, out_heading
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
// A write goes straight into the table. An interpolating query is accepted, then takes
// a read and a compare state per binary search step (12 steps at full depth), the
// bracket reads, the divider and the interpolation, then the output state; if the
// bracket times do not rise, the lower row is sent. A clamped query reads one row.
// One item is in flight at a time; ready drops while a query runs or its
// result waits on m_axis_tready. Reset is synchronous, active low.
module time_table_linear_interpolator_top #(
    parameter int TABLE_DEPTH   = ttli_pkg::TABLE_DEPTH_DEF,
    parameter int FRACTION_BITS = ttli_pkg::FRACTION_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic          s_axis_tuser,    // func
    // sample_index[11:0], sample_time, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    // heading, zero fill
    input  logic [271:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [1:0]    m_axis_tuser,    // boundary
    // out_x, out_y, out_z, out_vx, out_vy, out_vz, out_heading
    output logic [223:0]  m_axis_tdata,
    input  logic          i_cfg_we,
    input  logic [ttli_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ttli_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ttli_pkg::*;
    localparam int AW = $clog2(TABLE_DEPTH);

    t_state r_state, n_state;
    logic [COUNT_W-1:0] r_count;
    logic [FIELD_W-1:0] r_dur;
    logic               r_six;
    logic [FIELD_W-1:0] r_t;
    logic [AW:0]        r_lo, r_hi, n_lo, n_hi;
    logic [FIELD_W-1:0] r_t1, r_t2;
    t_row               r_row_lo, r_row_hi;
    logic [1:0]         r_bnd, n_bnd;
    t_row               r_res;
    logic [AW:0]        w_n, w_mid;
    logic [AW-1:0]      w_raddr;
    logic [FIELD_W-1:0] w_rtime;
    t_row               w_rrow, w_wrow, w_lres;
    logic               w_acc, w_we;
    logic [FIELD_W-1:0] w_num, w_den;
    logic               w_div_start, w_div_done, w_mul_start, w_mul_done;
    logic [FRACTION_BITS-1:0] w_frac;
    logic [AW:0]        r_sel, n_sel;
    logic               r_div_go;
    logic               r_emit;

    assign w_n = (r_count > COUNT_W'(TABLE_DEPTH)) ? (AW+1)'(TABLE_DEPTH)
                                                  : (AW+1)'(r_count);
    assign w_mid = (r_lo + r_hi) >> 1;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_we = w_acc && !s_axis_tuser
               && ({20'b0, s_axis_tdata[11:0]} < 32'(TABLE_DEPTH));

    always_comb begin
        for (int k = 0; k < NFIELD; k++)
            w_wrow[k] = s_axis_tdata[44 + 32*k +: 32];
    end

    ttli_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(AW'(s_axis_tdata[11:0])),
        .i_wtime(s_axis_tdata[43:12]), .i_wrow(w_wrow),
        .i_raddr(w_raddr), .o_rtime(w_rtime), .o_rrow(w_rrow));

    assign w_den = r_t2 - r_t1;
    assign w_num = (r_t > r_t1) ? (((r_t - r_t1) > w_den) ? w_den : r_t - r_t1) : '0;

    ttli_div #(.FB(FRACTION_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_num), .i_den(w_den), .o_done(w_div_done), .o_frac(w_frac));

    ttli_lerp #(.FB(FRACTION_BITS)) u_lerp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mul_start),
        .i_lo(r_row_lo), .i_hi(r_row_hi), .i_frac(w_frac),
        .o_done(w_mul_done), .o_res(w_lres));

    always_comb begin
        n_state = r_state;
        n_lo = r_lo;
        n_hi = r_hi;
        n_bnd = r_bnd;
        n_sel = r_sel;
        w_raddr = w_mid[AW-1:0];
        w_mul_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && s_axis_tuser && w_n != '0) begin
                    n_lo = '0;
                    n_hi = w_n - 1'b1;
                    if (s_axis_tdata[43:12] == '0) begin
                        n_bnd = BND_FIRST;
                        n_sel = '0;
                        n_state = ST_EMIT_RD;
                    end else if (s_axis_tdata[43:12] >= r_dur) begin
                        n_bnd = BND_LAST;
                        n_sel = w_n - 1'b1;
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_bnd = BND_INTERP;
                        n_state = ST_SRCH_RD;
                    end
                end
            end
            ST_SRCH_RD: begin
                if (r_lo + 1'b1 < r_hi) n_state = ST_SRCH_CMP;
                else begin
                    w_raddr = r_lo[AW-1:0];
                    n_state = ST_LO_RD;
                end
            end
            ST_SRCH_CMP: begin
                if (w_rtime <= r_t) n_lo = w_mid;
                else n_hi = w_mid;
                n_state = ST_SRCH_RD;
            end
            ST_LO_RD: begin
                w_raddr = r_hi[AW-1:0];
                n_state = ST_HI_RD;
            end
            ST_HI_RD: begin
                if (w_rtime <= r_t1) begin
                    n_sel = r_lo;
                    w_raddr = r_lo[AW-1:0];
                    n_state = ST_EMIT_RD;
                end else n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    w_mul_start = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: if (w_mul_done) n_state = ST_OUT;
            ST_EMIT_RD: begin
                w_raddr = r_sel[AW-1:0];
                n_state = ST_OUT;
            end
            ST_OUT: if (m_axis_tvalid && m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // The divider starts on entry to the divide state.
    assign w_div_start = r_div_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_dur    <= '0;
            r_six    <= 1'b0;
            r_div_go <= 1'b0;
            r_emit   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= (r_state == ST_HI_RD) && (n_state == ST_DIV);
            r_emit   <= (r_state == ST_EMIT_RD);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAMPLE_COUNT:   r_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_TOTAL_DURATION: r_dur   <= i_cfg_data;
                    CFG_SIX_DOF_MODE:   r_six   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        if (w_acc) r_t <= s_axis_tdata[43:12];
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_bnd <= n_bnd;
        r_sel <= n_sel;
        if (r_state == ST_LO_RD) begin
            r_t1 <= w_rtime;
            r_row_lo <= w_rrow;
        end
        if (r_state == ST_HI_RD) begin
            r_t2 <= w_rtime;
            r_row_hi <= w_rrow;
        end
        if (r_state == ST_MUL && w_mul_done) r_res <= w_lres;
        else if (r_emit) r_res <= w_rrow;
    end

    // A stored row is read in the emit-read state and registered while r_emit is high; valid waits for it.
    assign m_axis_tvalid = (r_state == ST_OUT) && !r_emit;
    assign m_axis_tuser  = r_bnd;

    always_comb begin
        for (int k = 0; k < NFIELD; k++)
            m_axis_tdata[32*k +: 32] = r_res[k];
        if (!r_six) m_axis_tdata[223:192] = '0;
    end
endmodule

>>> test/time_table_linear_interpolator_top_test.sv
`timescale 1ns / 100ps

module time_table_linear_interpolator_top_test;
    import ttli_pkg::*;

    localparam int DEPTH     = 4096;
    localparam int WDOG_MAX  = 5000;
    localparam int SETTLE    = 100;

    typedef struct {
        logic        func;
        logic [11:0] idx;
        logic [31:0] tstamp;
        logic [31:0] val [NFIELD];
    } sample_t;

    typedef struct {
        logic [31:0] val [NFIELD];
        logic [1:0]  bnd;
    } point_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic          s_axis_tuser = 1'b0;
    logic [271:0]  s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [1:0]    m_axis_tuser;
    logic [223:0]  m_axis_tdata;
    logic          i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    time_table_linear_interpolator_top dut (.*);

    // Shadow copy of the table and registers.
    logic [31:0] tbl_time [DEPTH];
    logic [31:0] tbl_val  [DEPTH][NFIELD];
    logic [12:0] cfg_count = '0;
    logic [31:0] cfg_dur = '0;
    logic        cfg_6dof = 1'b0;

    sample_t     sample_queue [$];
    point_t      expected_points [$];
    sample_t     in_flight;
    logic        took = 1'b0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          errors = 0;
    int          wdog = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies a write to the shadow table or works out a query's result; returns 1 when a result is due.
    function automatic bit apply_item(input sample_t s, output point_t p);
        int unsigned n, lo, hi, mid, num, den;
        longint unsigned quo, frac;
        longint a, b, r;
        p.bnd = BND_INTERP;
        for (int k = 0; k < NFIELD; k++) p.val[k] = '0;
        if (!s.func) begin
            tbl_time[s.idx] = s.tstamp;
            for (int k = 0; k < NFIELD; k++) tbl_val[s.idx][k] = s.val[k];
            return 1'b0;
        end
        n = (cfg_count > DEPTH) ? DEPTH : cfg_count;
        if (n == 0) return 1'b0;
        if (s.tstamp == 0) begin
            p.val = tbl_val[0];
            p.bnd = BND_FIRST;
        end else if (s.tstamp >= cfg_dur) begin
            p.val = tbl_val[n-1];
            p.bnd = BND_LAST;
        end else begin
            lo = 0;
            hi = n - 1;
            while (lo + 1 < hi) begin
                mid = (lo + hi) >> 1;
                if (tbl_time[mid] <= s.tstamp) lo = mid;
                else hi = mid;
            end
            if (tbl_time[hi] <= tbl_time[lo]) begin
                p.val = tbl_val[lo];
            end else begin
                den = tbl_time[hi] - tbl_time[lo];
                num = (s.tstamp > tbl_time[lo]) ? s.tstamp - tbl_time[lo] : 0;
                if (num > den) num = den;
                quo = (longint'(num) << FRACTION_BITS_DEF) / den;
                frac = (quo > 65535) ? 65535 : quo;
                for (int k = 0; k < NFIELD; k++) begin
                    a = longint'($signed(tbl_val[lo][k]));
                    b = longint'($signed(tbl_val[hi][k]));
                    r = a + (((b - a) * longint'(frac)) >>> FRACTION_BITS_DEF);
                    p.val[k] = r[31:0];
                end
            end
        end
        if (!cfg_6dof) p.val[NFIELD-1] = '0;
        return 1'b1;
    endfunction

    // Sender side: hold the current transfer until it is taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || took)) begin
            if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_flight = sample_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= in_flight.func;
                s_axis_tdata  <= {4'b0, in_flight.val[6], in_flight.val[5],
                                  in_flight.val[4], in_flight.val[3], in_flight.val[2],
                                  in_flight.val[1], in_flight.val[0], in_flight.tstamp,
                                  in_flight.idx};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        if (i_rst_n) m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        point_t  want;
        point_t  got;
        sample_t s;
        took <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                for (int k = 0; k < NFIELD; k++) got.val[k] = m_axis_tdata[32*k +: 32];
                got.bnd = m_axis_tuser;
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tuser=%0d",
                             $time, m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    want = expected_points.pop_front();
                    for (int k = 0; k < NFIELD; k++)
                        if (got.val[k] !== want.val[k]) begin
                            $display("%0t: field %0d expected %h actual %h",
                                     $time, k, want.val[k], got.val[k]);
                            errors++;
                        end
                    if (got.bnd !== want.bnd) begin
                        $display("%0t: boundary expected %0d actual %0d",
                                 $time, want.bnd, got.bnd);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                s.func   = s_axis_tuser;
                s.idx    = s_axis_tdata[11:0];
                s.tstamp = s_axis_tdata[43:12];
                for (int k = 0; k < NFIELD; k++) s.val[k] = s_axis_tdata[44 + 32*k +: 32];
                if (apply_item(s, want)) expected_points.push_back(want);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || i_cfg_we)
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_field();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(255) - 128;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_write(input int unsigned idx, input logic [31:0] t);
        sample_t s;
        s.func = 1'b0;
        s.idx = 12'(idx);
        s.tstamp = t;
        for (int k = 0; k < NFIELD; k++) s.val[k] = rand_field();
        sample_queue.push_back(s);
    endtask

    task automatic push_query(input logic [31:0] t);
        sample_t s;
        s.func = 1'b1;
        s.idx = 12'($urandom);
        s.tstamp = t;
        for (int k = 0; k < NFIELD; k++) s.val[k] = $urandom;
        sample_queue.push_back(s);
    endtask

    // Waits until every transfer has gone through and the block has settled.
    task automatic drain();
        while (sample_queue.size() > 0 || s_axis_tvalid || expected_points.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_SAMPLE_COUNT:   cfg_count = value[12:0];
            CFG_TOTAL_DURATION: cfg_dur = value;
            default:            cfg_6dof = value[0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Fills entries 0..n-1; times are sorted unless told otherwise.
    task automatic fill_table(input int unsigned n, input bit sorted,
                              output logic [31:0] last_t);
        logic [31:0] times [$];
        for (int i = 0; i < n; i++) times.push_back($urandom >> $urandom_range(12));
        if ($urandom_range(3) == 0 && n > 2) times[1] = times[2];
        if (sorted) times.sort();
        for (int i = 0; i < n; i++) push_write(i, times[i]);
        last_t = times[n-1];
    endtask

    initial begin
        logic [31:0] last_t;
        int unsigned n;
        int unsigned mode;
        logic [31:0] qt;
        logic [31:0] dir_times [9];

        dir_times = '{32'd0, 32'd1, 32'd50, 32'd100, 32'd150, 32'd250, 32'd299,
                      32'hFFFF_FFFE, 32'hFFFF_FFFF};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty table, duplicate and descending times, field extremes.
        push_query(32'd5);
        push_write(0, 32'd0);
        push_write(1, 32'd100);
        push_write(2, 32'd100);
        push_write(3, 32'd300);
        push_write(4, 32'd200);
        push_write(5, 32'hFFFF_FFFF);
        push_write(4095, 32'd7);
        drain();
        write_reg(CFG_SAMPLE_COUNT, 32'd6);
        write_reg(CFG_TOTAL_DURATION, 32'hFFFF_FFFF);
        write_reg(CFG_SIX_DOF_MODE, 32'd1);
        foreach (dir_times[i])
            push_query(dir_times[i]);
        drain();
        write_reg(CFG_SAMPLE_COUNT, 32'd1);
        write_reg(CFG_TOTAL_DURATION, 32'd0);
        write_reg(CFG_SIX_DOF_MODE, 32'd0);
        push_query(32'd0);
        push_query(32'd7);
        drain();
        write_reg(CFG_TOTAL_DURATION, 32'd1000);
        push_query(32'd500);
        drain();

        // Random phases over the idling modes.
        for (int ph = 0; ph < 14; ph++) begin
            mode = ph % 4;
            send_idle_pct = (mode == 1) ? 77 : (mode == 3) ? 20 : 0;
            stall_pct     = (mode == 2) ? 77 : (mode == 3) ? 20 : 0;
            n = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            fill_table(n, $urandom_range(4) != 0, last_t);
            drain();
            write_reg(CFG_SAMPLE_COUNT, ($urandom_range(5) == 0) ? 32'd0 : n);
            case ($urandom_range(5))
                0:       write_reg(CFG_TOTAL_DURATION, 32'd0);
                1:       write_reg(CFG_TOTAL_DURATION, 32'hFFFF_FFFF);
                default: write_reg(CFG_TOTAL_DURATION, last_t - $urandom_range(3));
            endcase
            write_reg(CFG_SIX_DOF_MODE, $urandom_range(1));
            for (int i = 0; i < 24; i++) begin
                if ($urandom_range(4) == 0) begin
                    // Writes may land anywhere; entries below the count stay valid.
                    push_write($urandom_range(1) ? $urandom_range(4095)
                                                 : $urandom_range(n - 1), $urandom);
                end else begin
                    case ($urandom_range(7))
                        0:       qt = 32'd0;
                        1:       qt = cfg_dur;
                        2:       qt = $urandom;
                        3:       qt = tbl_time[$urandom_range(n - 1)];
                        default: qt = $urandom_range(last_t);
                    endcase
                    push_query(qt);
                end
            end
            drain();
        end

        // An oversized count acts as the full depth; clamped queries read only the
        // first and the last entry, both written above.
        send_idle_pct = 20;
        stall_pct = 20;
        write_reg(CFG_SAMPLE_COUNT, 32'd8191);
        write_reg(CFG_TOTAL_DURATION, 32'd3000 * 1024);
        write_reg(CFG_SIX_DOF_MODE, 32'd1);
        for (int i = 0; i < 20; i++)
            push_query($urandom_range(1) ? 32'd0
                                         : $urandom_range(32'hFFFF_FFFF, 32'd3000 * 1024));
        drain();

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/ttli_pkg.sv
hdl/ttli_mem.sv
hdl/ttli_div.sv
hdl/ttli_lerp.sv
hdl/time_table_linear_interpolator_top.sv
test/time_table_linear_interpolator_top_test.sv
